/* rtl/bpc_pkg.sv */
// Shared types and constants for the button press classifier.
// No dependencies; the top level refers to these by scoped names.
package bpc_pkg;

   // Field widths of one poll beat and one result beat.
   localparam int TICK_W  = 6;
   localparam int MS_W    = 10;
   localparam int EVENT_W = 3;
   localparam int REQ_W   = 8;
   localparam int RSP_W   = 8;
   localparam int IDX_W   = 2;

   // Each tick is 16 ms, so elapsed ms is the tick difference shifted left by four.
   localparam int TICK_SHIFT = 4;

   // Event codes on the result channel.
   typedef enum logic [EVENT_W-1:0] {
      EV_NONE      = 3'd0,
      EV_SHORT     = 3'd1,
      EV_FIRSTLONG = 3'd2,
      EV_REPEAT    = 3'd3,
      EV_DONE      = 3'd4
   } event_type;

   // Configuration register indexes.
   localparam logic [IDX_W-1:0] REG_PRESS_DEB   = 2'd0;
   localparam logic [IDX_W-1:0] REG_FIRST_LONG  = 2'd1;
   localparam logic [IDX_W-1:0] REG_REPEAT_LONG = 2'd2;
   localparam logic [IDX_W-1:0] REG_RELEASE_DEB = 2'd3;

   // Reset values of the configuration registers, in milliseconds.
   localparam logic [MS_W-1:0] PRESS_DEB_RST   = 10'd48;
   localparam logic [MS_W-1:0] FIRST_LONG_RST  = 10'd512;
   localparam logic [MS_W-1:0] REPEAT_LONG_RST = 10'd256;
   localparam logic [MS_W-1:0] RELEASE_DEB_RST = 10'd96;

endpackage

/* rtl/button_press_classifier.sv */
// An accepted poll beat passes the input register, then the state update and result
// register. Throughput: one poll beat per cycle unless the result channel stalls;
// an empty input stage still fills while a result waits.
// Reset (synchronous, active high) empties both stages, returns the machine to idle,
// clears the change stamp and loads the default thresholds.
// Depends on bpc_pkg.
module button_press_classifier (
   input  logic                       clock,
   input  logic                       reset,
   // Poll channel.
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [bpc_pkg::REQ_W-1:0]  req_tdata,   // [0] pin_released, [6:1] time_ticks
   // Result channel.
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [bpc_pkg::RSP_W-1:0]  rsp_tdata,   // [2:0] event_code, [3] held
   // Configuration port.
   input  logic                       csr_we,
   input  logic [bpc_pkg::IDX_W-1:0]  csr_index,
   input  logic [bpc_pkg::MS_W-1:0]   csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE      = 3'd0,
      ST_PDEBOUNCE = 3'd1,
      ST_RDEBOUNCE = 3'd2,
      ST_PRESSED   = 3'd3,
      ST_LONG      = 3'd4,
      ST_LONGREL   = 3'd5,
      ST_SHORTREL  = 3'd6
   } state_type;

   // Configuration registers.
   logic [bpc_pkg::MS_W-1:0]   press_deb_ff;
   logic [bpc_pkg::MS_W-1:0]   first_long_ff;
   logic [bpc_pkg::MS_W-1:0]   repeat_long_ff;
   logic [bpc_pkg::MS_W-1:0]   release_deb_ff;

   // Input stage.
   logic                       in_valid_ff;
   logic                       in_released_ff;
   logic [bpc_pkg::TICK_W-1:0] in_ticks_ff;

   // Machine state.
   state_type                  state_ff;
   state_type                  state_in;
   logic [bpc_pkg::TICK_W-1:0] stamp_ff;
   logic [bpc_pkg::TICK_W-1:0] stamp_in;

   // Result stage.
   logic                       out_valid_ff;
   bpc_pkg::event_type         event_ff;
   bpc_pkg::event_type         event_in;
   logic                       held_ff;
   logic                       held_in;

   logic                       out_free;
   logic                       advance;
   logic [bpc_pkg::TICK_W-1:0] tick_diff;
   logic [bpc_pkg::MS_W-1:0]   elapsed_ms;

   // The result stage takes a new beat when empty or when its beat leaves now.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(bpc_pkg::RSP_W - bpc_pkg::EVENT_W - 1){1'b0}}, held_ff, event_ff};

   // Elapsed time wraps modulo 64 ticks, then scales to milliseconds.
   assign tick_diff  = in_ticks_ff - stamp_ff;
   assign elapsed_ms = {tick_diff, {bpc_pkg::TICK_SHIFT{1'b0}}};

   // Next state, stamp and event for the poll in the input stage.
   always_comb begin
      state_in = state_ff;
      stamp_in = stamp_ff;
      event_in = bpc_pkg::EV_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (!in_released_ff) begin
               state_in = ST_PDEBOUNCE;
               stamp_in = in_ticks_ff;
            end
         end
         ST_PDEBOUNCE: begin
            if (in_released_ff) begin
               state_in = ST_IDLE;
            end else if (elapsed_ms >= press_deb_ff) begin
               state_in = ST_PRESSED;
            end
         end
         ST_PRESSED: begin
            if (in_released_ff) begin
               state_in = ST_SHORTREL;
               stamp_in = in_ticks_ff;
            end else if (elapsed_ms >= first_long_ff) begin
               event_in = bpc_pkg::EV_FIRSTLONG;
               state_in = ST_LONG;
               stamp_in = in_ticks_ff;
            end
         end
         ST_LONG: begin
            if (in_released_ff) begin
               state_in = ST_LONGREL;
            end else if (elapsed_ms >= repeat_long_ff) begin
               event_in = bpc_pkg::EV_REPEAT;
               stamp_in = in_ticks_ff;
            end
         end
         ST_LONGREL: begin
            if (in_released_ff) begin
               event_in = bpc_pkg::EV_DONE;
               state_in = ST_RDEBOUNCE;
               stamp_in = in_ticks_ff;
            end else begin
               state_in = ST_LONG;
            end
         end
         ST_SHORTREL: begin
            if (in_released_ff) begin
               event_in = bpc_pkg::EV_SHORT;
               state_in = ST_RDEBOUNCE;
            end else begin
               state_in = ST_PRESSED;
            end
         end
         ST_RDEBOUNCE: begin
            if (in_released_ff) begin
               if (elapsed_ms >= release_deb_ff) begin
                  state_in = ST_IDLE;
               end
            end else begin
               stamp_in = in_ticks_ff;
            end
         end
         default: begin
            // The unused code holds its place and gives no event.
            state_in = state_ff;
         end
      endcase
      held_in = (event_in == bpc_pkg::EV_NONE) && (state_in > ST_RDEBOUNCE);
   end

   // State, pipeline stages and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         state_ff       <= ST_IDLE;
         stamp_ff       <= '0;
         press_deb_ff   <= bpc_pkg::PRESS_DEB_RST;
         first_long_ff  <= bpc_pkg::FIRST_LONG_RST;
         repeat_long_ff <= bpc_pkg::REPEAT_LONG_RST;
         release_deb_ff <= bpc_pkg::RELEASE_DEB_RST;
      end else begin
         // Configuration writes.
         if (csr_we) begin
            unique case (csr_index)
               bpc_pkg::REG_PRESS_DEB:   press_deb_ff   <= csr_wdata;
               bpc_pkg::REG_FIRST_LONG:  first_long_ff  <= csr_wdata;
               bpc_pkg::REG_REPEAT_LONG: repeat_long_ff <= csr_wdata;
               bpc_pkg::REG_RELEASE_DEB: release_deb_ff <= csr_wdata;
               default: ;
            endcase
         end

         // Input stage takes a beat whenever it is empty or moving on.
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end

         // Result stage and machine update.
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            state_ff <= state_in;
            stamp_ff <= stamp_in;
         end
      end

      // Payload registers carry no reset.
      if (req_tready && req_tvalid) begin
         in_released_ff <= req_tdata[0];
         in_ticks_ff    <= req_tdata[bpc_pkg::TICK_W:1];
      end
      if (advance) begin
         event_ff <= event_in;
         held_ff  <= held_in;
      end
   end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for button_press_classifier: directed and random poll beats,
// predicted in a scoreboard class and checked against every result beat.
// Depends on bpc_pkg and the button_press_classifier top level.
module tb;
   import bpc_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int MAX_PRINTED    = 40;

   // Machine states, encoded as the block encodes them.
   typedef enum logic [2:0] {
      BTN_IDLE        = 3'd0,
      BTN_PRESS_DEB   = 3'd1,
      BTN_RELEASE_DEB = 3'd2,
      BTN_PRESSED     = 3'd3,
      BTN_LONG        = 3'd4,
      BTN_LONG_REL    = 3'd5,
      BTN_SHORT_REL   = 3'd6
   } btn_state;

   typedef struct {
      event_type ev;
      bit        held;
   } poll_outcome;

   // Scoreboard: tracks the button state per accepted poll and checks result beats.
   class press_scoreboard;
      btn_state          state;
      logic [TICK_W-1:0] stamp;
      logic [MS_W-1:0]   press_deb, first_long, repeat_long, release_deb;
      poll_outcome       outcomes[$];
      int                errors;
      int                polls;
      int                checked;
      int                fired[8];

      function new();
         state       = BTN_IDLE;
         stamp       = '0;
         press_deb   = PRESS_DEB_RST;
         first_long  = FIRST_LONG_RST;
         repeat_long = REPEAT_LONG_RST;
         release_deb = RELEASE_DEB_RST;
      endfunction

      function void set_threshold(logic [IDX_W-1:0] idx, logic [MS_W-1:0] value);
         case (idx)
            REG_PRESS_DEB:   press_deb   = value;
            REG_FIRST_LONG:  first_long  = value;
            REG_REPEAT_LONG: repeat_long = value;
            REG_RELEASE_DEB: release_deb = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return outcomes.size();
      endfunction

      // Advance the machine by one accepted poll beat and queue the outcome it gives.
      function void note_poll(bit released, logic [TICK_W-1:0] now);
         logic [TICK_W-1:0] dt;
         logic [MS_W-1:0]   waited;
         btn_state          nxt;
         event_type         ev;
         poll_outcome       res;
         dt     = now - stamp;
         waited = MS_W'(dt) << TICK_SHIFT;
         nxt    = state;
         ev     = EV_NONE;
         case (state)
            BTN_IDLE:
               if (!released) begin
                  nxt   = BTN_PRESS_DEB;
                  stamp = now;
               end
            BTN_PRESS_DEB:
               if (released) nxt = BTN_IDLE;
               else if (waited >= press_deb) nxt = BTN_PRESSED;
            BTN_PRESSED:
               if (released) begin
                  nxt   = BTN_SHORT_REL;
                  stamp = now;
               end else if (waited >= first_long) begin
                  ev    = EV_FIRSTLONG;
                  nxt   = BTN_LONG;
                  stamp = now;
               end
            BTN_LONG:
               if (released) nxt = BTN_LONG_REL;
               else if (waited >= repeat_long) begin
                  ev    = EV_REPEAT;
                  stamp = now;
               end
            BTN_LONG_REL:
               if (released) begin
                  ev    = EV_DONE;
                  nxt   = BTN_RELEASE_DEB;
                  stamp = now;
               end else begin
                  nxt = BTN_LONG;
               end
            BTN_SHORT_REL:
               if (released) begin
                  ev  = EV_SHORT;
                  nxt = BTN_RELEASE_DEB;
               end else begin
                  nxt = BTN_PRESSED;
               end
            BTN_RELEASE_DEB:
               if (!released) stamp = now;
               else if (waited >= release_deb) nxt = BTN_IDLE;
            default: ;
         endcase
         state    = nxt;
         res.ev   = ev;
         res.held = (ev == EV_NONE) && (nxt > BTN_RELEASE_DEB);
         outcomes.push_back(res);
         fired[int'(ev)]++;
         polls++;
      endfunction

      task report(string what);
         errors++;
         if (errors <= MAX_PRINTED) $display("tb: mismatch: %s", what);
      endtask

      // Compare one result beat, field by field, with the oldest outcome.
      task check_result(logic [RSP_W-1:0] beat);
         poll_outcome res;
         checked++;
         if (outcomes.size() == 0) begin
            report($sformatf("result beat %0d (0x%02h) with no poll outstanding",
                             checked, beat));
            return;
         end
         res = outcomes.pop_front();
         if (beat[EVENT_W-1:0] !== res.ev)
            report($sformatf("result beat %0d event_code %0d, predicted %0d",
                             checked, beat[EVENT_W-1:0], res.ev));
         if (beat[EVENT_W] !== res.held)
            report($sformatf("result beat %0d held %0b, predicted %0b",
                             checked, beat[EVENT_W], res.held));
      endtask
   endclass

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata  = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;
   logic               csr_we     = 1'b0;
   logic [IDX_W-1:0]   csr_index  = '0;
   logic [MS_W-1:0]    csr_wdata  = '0;

   press_scoreboard    board = new();
   logic [TICK_W-1:0]  tick_now = '0;
   int                 gap_pct   = 0;
   int                 stall_pct = 0;
   int                 idle_cycles = 0;
   int                 settings = 0;

   always #1 clock = ~clock;

   button_press_classifier i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Result receiver: stalls at random according to the current stall rate.
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Beat monitors on both channels.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         board.note_poll(req_tdata[0], req_tdata[TICK_W:1]);
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tdata);
   end

   // Watchdog: ends the run when no beat moves for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("tb: timeout, no beat moved for %0d cycles", WATCHDOG_LIMIT);
         $display("tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one poll beat, with random gaps first, and return once it is taken.
   task automatic send_poll(input bit released, input logic [TICK_W-1:0] ticks);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, ticks, released};
      tick_now   = ticks;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic step_poll(input bit released, input int advance);
      send_poll(released, tick_now + TICK_W'(advance));
   endtask

   // Hold the sender until every outstanding poll has its result.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all four thresholds while the block is idle.
   task automatic load_thresholds(input logic [MS_W-1:0] p, f, r, d);
      logic [MS_W-1:0]  vals[4];
      logic [IDX_W-1:0] regs[4];
      drain();
      vals = '{p, f, r, d};
      regs = '{REG_PRESS_DEB, REG_FIRST_LONG, REG_REPEAT_LONG, REG_RELEASE_DEB};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         board.set_threshold(regs[i], vals[i]);
      end
      csr_we <= 1'b0;
      settings++;
   endtask

   // One press from idle to release: optional contact bounce, a hold of random
   // length, an occasional bounce on release, then released polls.
   task automatic press_cycle();
      int hold_ticks;
      int held_so_far;
      int adv;
      int n;
      case ($urandom_range(2))
         0:       hold_ticks = $urandom_range(1, 8);
         1:       hold_ticks = $urandom_range(9, 40);
         default: hold_ticks = $urandom_range(41, 140);
      endcase
      n = $urandom_range(0, 3);
      repeat (n) step_poll(1'b1, $urandom_range(0, 3));
      if ($urandom_range(1)) begin
         n = $urandom_range(1, 3);
         repeat (n) begin
            step_poll(1'b0, $urandom_range(0, 1));
            step_poll(1'b1, $urandom_range(0, 1));
         end
      end
      held_so_far = 0;
      while (held_so_far < hold_ticks) begin
         adv = ($urandom_range(19) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 4);
         held_so_far += adv;
         step_poll(1'b0, adv);
      end
      if ($urandom_range(3) == 0) begin
         step_poll(1'b1, $urandom_range(0, 1));
         step_poll(1'b0, 0);
      end
      n = $urandom_range(1, 12);
      repeat (n) begin
         // A brief press during release debounce restarts its timer.
         if ($urandom_range(9) == 0) step_poll(1'b0, $urandom_range(0, 2));
         step_poll(1'b1, $urandom_range(0, 4));
      end
   endtask

   task automatic noise_burst();
      int n;
      n = $urandom_range(1, 6);
      repeat (n) send_poll(1'($urandom_range(1)), TICK_W'($urandom_range(0, 63)));
   endtask

   // Random stimulus up to a poll count, with one full drain midway.
   task automatic random_phase(input int count);
      int target;
      int halfway;
      bit paused;
      target  = board.polls + count;
      halfway = board.polls + count / 2;
      paused  = 1'b0;
      while (board.polls < target) begin
         if (!paused && board.polls >= halfway) begin
            drain();
            paused = 1'b1;
         end
         if ($urandom_range(99) < 80) press_cycle();
         else noise_burst();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part at reset thresholds: short press with bounce, then a long
      // press across the tick wrap with a repeat, a release bounce and long done.
      gap_pct   = 15;
      stall_pct = 52;
      send_poll(1'b1, 6'd0);
      send_poll(1'b0, 6'd0);
      send_poll(1'b0, 6'd1);
      send_poll(1'b0, 6'd3);
      send_poll(1'b1, 6'd4);
      send_poll(1'b0, 6'd4);
      send_poll(1'b1, 6'd5);
      send_poll(1'b1, 6'd5);
      send_poll(1'b0, 6'd6);
      send_poll(1'b1, 6'd8);
      send_poll(1'b1, 6'd12);
      send_poll(1'b0, 6'd60);
      send_poll(1'b0, 6'd63);
      send_poll(1'b0, 6'd63);
      send_poll(1'b0, 6'd10);
      send_poll(1'b0, 6'd28);
      send_poll(1'b0, 6'd40);
      send_poll(1'b0, 6'd44);
      send_poll(1'b1, 6'd45);
      send_poll(1'b0, 6'd45);
      send_poll(1'b1, 6'd46);
      send_poll(1'b1, 6'd46);
      send_poll(1'b1, 6'd50);
      send_poll(1'b1, 6'd52);

      // Random phases over a range of threshold settings and idle patterns.
      random_phase(60);
      load_thresholds(10'd0, 10'd0, 10'd0, 10'd0);
      random_phase(45);
      load_thresholds(10'd1023, 10'd1023, 10'd1023, 10'd1023);
      random_phase(30);

      gap_pct   = 52;
      stall_pct = 15;
      load_thresholds(10'd16, 10'd96, 10'd32, 10'd16);
      random_phase(80);
      load_thresholds(10'd0, 10'd1023, 10'd0, 10'd1008);
      random_phase(45);
      load_thresholds(MS_W'($urandom_range(0, 1023)), MS_W'($urandom_range(0, 1023)),
                      MS_W'($urandom_range(0, 1023)), MS_W'($urandom_range(0, 1023)));
      random_phase(60);

      gap_pct   = 0;
      stall_pct = 0;
      load_thresholds(10'd1008, 10'd1008, 10'd1008, 10'd0);
      random_phase(40);
      load_thresholds(MS_W'($urandom_range(0, 200)), MS_W'($urandom_range(0, 200)),
                      MS_W'($urandom_range(0, 200)), MS_W'($urandom_range(0, 200)));
      random_phase(80);
      load_thresholds(PRESS_DEB_RST, FIRST_LONG_RST, REPEAT_LONG_RST, RELEASE_DEB_RST);
      random_phase(60);

      drain();
      repeat (8) @(posedge clock);

      $display("tb: %0d polls and %0d result beats over %0d threshold settings",
               board.polls, board.checked, settings + 1);
      $display("tb: short %0d, first long %0d, repeat %0d, long done %0d, mismatches %0d",
               board.fired[EV_SHORT], board.fired[EV_FIRSTLONG], board.fired[EV_REPEAT],
               board.fired[EV_DONE], board.errors);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end
endmodule
